// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and held off
// while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every edge outside reset.
`define SCT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define SCT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define SCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sct_pkg.sv =====
// ---------------------------------------------------------------------------
// sct_pkg
// Types, sizes and helpers shared by the saturating coverage table.
// ---------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

  // Table geometry
  localparam int POSITIONS   = 4096;
  localparam int CATEGORIES  = 4;
  localparam int COUNT_W     = 16;
  localparam int POS_W       = $clog2(POSITIONS);
  localparam int CAT_W       = $clog2(CATEGORIES);
  localparam int MEM_DEPTH   = POSITIONS * CATEGORIES;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int CNT_W       = $clog2(POSITIONS + 1);
  localparam int SUM_W       = COUNT_W + 1;

  // Request field widths
  localparam int OPCODE_W    = 3;
  localparam int POS_IN_W    = 16;
  localparam int CAT_IN_W    = 2;
  localparam int SPAN_W      = 13;
  localparam int EXT_W       = POS_IN_W + 1;

  // Configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int LIMIT_W     = 13;
  localparam logic [COUNT_W-1:0] MAX_RESET   = COUNT_W'(65535);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);

  // Command queue
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_COVERAGE = 2'd0,
    REG_POSITIONS    = 2'd1,
    REG_SPARE2       = 2'd2,
    REG_SPARE3       = 2'd3
  } cfg_reg_e;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INC       = 3'd0,
    OP_ADD       = 3'd1,
    OP_INC_RANGE = 3'd2,
    OP_ADD_RANGE = 3'd3,
    OP_SET       = 3'd4,
    OP_READ      = 3'd5,
    OP_TEST_HIGH = 3'd6,
    OP_CLEAR     = 3'd7
  } opcode_e;

  // Work handed from the front to the back
  typedef enum logic [2:0] {
    K_NOP,
    K_INC,
    K_ADD,
    K_RADD,
    K_SET,
    K_READ,
    K_TEST,
    K_CLEAR
  } cmd_kind_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [POS_IN_W-1:0] position;
    logic [CAT_IN_W-1:0] category;
    logic [SPAN_W-1:0]   span;
    logic [COUNT_W-1:0]  amount;
  } in_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] coverage_value;
    logic               is_high;
  } out_rsp_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   pos_mid;
    logic [POS_W-1:0]   pos_end;
    logic [CAT_W-1:0]   cat;
    logic [CNT_W-1:0]   count;
    logic [COUNT_W-1:0] amount;
  } cmd_t;

  // Flat counter address of one position and category
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [POS_W-1:0] pos,
                                                  input logic [CAT_W-1:0] cat);
    return ADDR_W'(pos) * ADDR_W'(CATEGORIES) + ADDR_W'(cat);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sct_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// sct_cmd_fifo
// Short command queue between the decode front and the execution back.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sct_cmd_fifo import sct_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      head_o
);

  cmd_t                  entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `SCT_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push_i, !full_o, "push into full queue")
  `SCT_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop_i, !empty_o, "pop from empty queue")
  `SCT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= FIFO_CNT_W'(FIFO_DEPTH), "count overrun")

endmodule

`default_nettype wire

// ===== rtl/sct_front.sv =====
// ---------------------------------------------------------------------------
// sct_front
// Accepts requests, checks them against the live limits and turns each
// into a command with a clipped run length for the execution back.
// ---------------------------------------------------------------------------
`default_nettype none

module sct_front import sct_pkg::*; (
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  in_req_t                 in_req_i,
  input  wire logic [LIMIT_W-1:0] positions_in_use_i,
  input  wire logic               fifo_full_i,
  input  wire logic               init_busy_i,
  output logic                    push_o,
  output cmd_t                    push_cmd_o
);

  logic [CNT_W-1:0] lim;
  logic [EXT_W-1:0] p_ext;
  logic [EXT_W-1:0] lim_ext;
  logic [EXT_W-1:0] end_full;
  logic [EXT_W-1:0] end_clip;
  logic [EXT_W-1:0] mid_pos;
  logic [EXT_W-1:0] run_len;
  logic             pos_ok;
  logic             cat_ok;
  logic             test_ok;

  // Hold requests while the queue is full or the reset clearing pass is still running
  assign in_stall_o = fifo_full_i || init_busy_i;
  assign push_o     = in_valid_i && !in_stall_o;

  // Effective limit and run bounds
  assign lim      = (CNT_W'(positions_in_use_i) < CNT_W'(POSITIONS)) ?
                    CNT_W'(positions_in_use_i) : CNT_W'(POSITIONS);
  assign p_ext    = EXT_W'(in_req_i.position);
  assign lim_ext  = EXT_W'(lim);
  assign end_full = p_ext + EXT_W'(in_req_i.span);
  assign mid_pos  = p_ext + EXT_W'(in_req_i.span >> 1);
  assign end_clip = (end_full > lim_ext) ? lim_ext : end_full;
  assign run_len  = (end_clip > p_ext) ? end_clip - p_ext : '0;
  assign pos_ok   = p_ext < lim_ext;
  assign cat_ok   = int'(in_req_i.category) < CATEGORIES;
  assign test_ok  = end_full < lim_ext;

  // Classify the request
  always_comb begin
    push_cmd_o.kind    = K_NOP;
    push_cmd_o.pos     = POS_W'(in_req_i.position);
    push_cmd_o.pos_mid = POS_W'(mid_pos);
    push_cmd_o.pos_end = POS_W'(end_full);
    push_cmd_o.cat     = CAT_W'(in_req_i.category);
    push_cmd_o.count   = CNT_W'(1);
    push_cmd_o.amount  = in_req_i.amount;
    unique case (opcode_e'(in_req_i.opcode))
      OP_CLEAR: begin
        push_cmd_o.kind = K_CLEAR;
      end
      OP_INC: begin
        push_cmd_o.kind = (cat_ok && pos_ok) ? K_INC : K_NOP;
      end
      OP_ADD: begin
        push_cmd_o.kind = (cat_ok && pos_ok) ? K_ADD : K_NOP;
      end
      OP_INC_RANGE: begin
        push_cmd_o.count = CNT_W'(run_len);
        push_cmd_o.kind  = (cat_ok && run_len != '0) ? K_INC : K_NOP;
      end
      OP_ADD_RANGE: begin
        push_cmd_o.count = CNT_W'(run_len);
        push_cmd_o.kind  = (cat_ok && run_len != '0) ? K_RADD : K_NOP;
      end
      OP_SET: begin
        push_cmd_o.kind = (cat_ok && pos_ok) ? K_SET : K_NOP;
      end
      OP_READ: begin
        push_cmd_o.kind = (cat_ok && pos_ok) ? K_READ : K_NOP;
      end
      OP_TEST_HIGH: begin
        push_cmd_o.kind = (cat_ok && test_ok) ? K_TEST : K_NOP;
      end
      default: begin
        push_cmd_o.kind = K_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sct_back.sv =====
// ---------------------------------------------------------------------------
// sct_back
// Executes queued commands on the counter memory with read-modify-write
// steps, runs clearing passes and drives the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sct_back import sct_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fifo_empty_i,
  input  cmd_t                    fifo_cmd_i,
  output logic                    fifo_pop_o,
  input  wire logic [COUNT_W-1:0] max_cov_i,
  output logic                    init_busy_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_rsp_t                out_rsp_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_TEST,
    S_HOLD
  } state_e;

  state_e             state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   remain_q, remain_d;
  logic [1:0]         step_q, step_d;
  logic               hit_q, hit_d;
  logic [ADDR_W-1:0]  clr_addr_q, clr_addr_d;
  logic               clr_emit_q, clr_emit_d;
  out_rsp_t           res_q, res_d;
  logic               out_valid_q, out_valid_d;
  out_rsp_t           out_rsp_q, out_rsp_d;

  logic [COUNT_W-1:0] mem [MEM_DEPTH];
  logic [COUNT_W-1:0] rd_q;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [COUNT_W-1:0] wr_data;

  logic               out_free;
  logic               out_load;
  logic               fin;
  out_rsp_t           fin_rsp;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   max_ext;
  logic               at_max;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign init_busy_o = (state_q == S_CLEAR) && !clr_emit_q;
  assign sum         = SUM_W'(rd_q) + SUM_W'(cmd_q.amount);
  assign max_ext     = SUM_W'(max_cov_i);
  assign at_max      = rd_q >= max_cov_i;

  // Sequence commands through the memory
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    remain_d    = remain_q;
    step_d      = step_q;
    hit_d       = hit_q;
    clr_addr_d  = clr_addr_q;
    clr_emit_d  = clr_emit_q;
    res_d       = res_q;
    out_rsp_d   = out_rsp_q;
    out_load    = 1'b0;
    fin         = 1'b0;
    fin_rsp     = '0;
    fifo_pop_o  = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;

    unique case (state_q)
      S_CLEAR: begin
        wr_en      = 1'b1;
        wr_addr    = clr_addr_q;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
          clr_emit_d = 1'b0;
          if (clr_emit_q) begin
            fin = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (!fifo_empty_i) begin
          fifo_pop_o = 1'b1;
          cmd_d      = fifo_cmd_i;
          pos_d      = fifo_cmd_i.pos;
          remain_d   = fifo_cmd_i.count;
          step_d     = '0;
          hit_d      = 1'b1;
          unique case (fifo_cmd_i.kind)
            K_NOP: begin
              fin = 1'b1;
            end
            K_CLEAR: begin
              clr_addr_d = '0;
              clr_emit_d = 1'b1;
              state_d    = S_CLEAR;
            end
            K_TEST: begin
              rd_en   = 1'b1;
              rd_addr = slot_addr(fifo_cmd_i.pos, fifo_cmd_i.cat);
              state_d = S_TEST;
            end
            default: begin
              rd_en   = 1'b1;
              rd_addr = slot_addr(fifo_cmd_i.pos, fifo_cmd_i.cat);
              state_d = S_RMW;
            end
          endcase
        end
      end

      S_RMW: begin
        wr_addr = slot_addr(pos_q, cmd_q.cat);
        unique case (cmd_q.kind)
          K_INC: begin
            wr_en   = rd_q < max_cov_i;
            wr_data = rd_q + 1'b1;
          end
          K_ADD: begin
            wr_en   = sum < max_ext;
            wr_data = COUNT_W'(sum);
          end
          K_RADD: begin
            wr_en   = sum <= max_ext;
            wr_data = COUNT_W'(sum);
          end
          K_SET: begin
            wr_en   = cmd_q.amount <= max_cov_i;
            wr_data = cmd_q.amount;
          end
          default: begin
            wr_en = 1'b0;
          end
        endcase
        // Fetch the next position of a run while writing this one
        if (remain_q > CNT_W'(1)) begin
          remain_d = remain_q - 1'b1;
          pos_d    = pos_q + 1'b1;
          rd_en    = 1'b1;
          rd_addr  = slot_addr(pos_q + 1'b1, cmd_q.cat);
        end else begin
          fin = 1'b1;
          if (cmd_q.kind == K_READ) begin
            fin_rsp.coverage_value = rd_q;
          end
        end
      end

      S_TEST: begin
        hit_d = hit_q && at_max;
        unique case (step_q)
          2'd0: begin
            rd_en   = 1'b1;
            rd_addr = slot_addr(cmd_q.pos_mid, cmd_q.cat);
            step_d  = 2'd1;
          end
          2'd1: begin
            rd_en   = 1'b1;
            rd_addr = slot_addr(cmd_q.pos_end, cmd_q.cat);
            step_d  = 2'd2;
          end
          default: begin
            fin             = 1'b1;
            fin_rsp.is_high = hit_q && at_max;
          end
        endcase
      end

      S_HOLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_rsp_d = res_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Deliver the result now or park it until the output frees up
    if (fin) begin
      if (out_free) begin
        out_load  = 1'b1;
        out_rsp_d = fin_rsp;
        state_d   = S_IDLE;
      end else begin
        res_d   = fin_rsp;
        state_d = S_HOLD;
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // State and registered outputs; reset starts a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      clr_emit_q  <= 1'b0;
      out_valid_q <= 1'b0;
      remain_q    <= '0;
      step_q      <= '0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      clr_emit_q  <= clr_emit_d;
      out_valid_q <= out_valid_d;
      remain_q    <= remain_d;
      step_q      <= step_d;
      hit_q       <= hit_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    pos_q     <= pos_d;
    res_q     <= res_d;
    out_rsp_q <= out_rsp_d;
  end

  // Counter memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  `SCT_ASSERT_IMPL(a_rmw_has_work, clk_i, rst_ni, state_q == S_RMW, remain_q != '0,
                   "read-modify-write with empty run")
  `SCT_ASSERT_IMPL(a_load_when_free, clk_i, rst_ni, out_load, out_free,
                   "result overwrites a pending result")
  `SCT_ASSERT_NEXT(a_clear_sweep, clk_i, rst_ni,
                   state_q == S_CLEAR && clr_addr_q != ADDR_W'(MEM_DEPTH - 1),
                   state_q == S_CLEAR && clr_addr_q == ADDR_W'($past(clr_addr_q) + 1'b1),
                   "clearing pass skipped an entry")

endmodule

`default_nettype wire

// ===== rtl/saturating_coverage_table.sv =====
// ---------------------------------------------------------------------------
// saturating_coverage_table: capped coverage counters by position and category
// Requests are queued and the back runs one at a time: a single-entry request is read
// and written back, a range request walks its positions one by one, a high test reads
// the start, middle and end positions, a clear writes every counter, and an ignored
// request still returns a result. The queue takes requests while the back is busy until
// it fills. Reset runs a clearing pass with requests stalled; registers return to reset values.
// ---------------------------------------------------------------------------
`default_nettype none

module saturating_coverage_table import sct_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  in_req_t                    in_req_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_rsp_t                   out_rsp_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [COUNT_W-1:0] max_cov_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               push;
  cmd_t               push_cmd;
  logic               fifo_full;
  logic               fifo_empty;
  logic               fifo_pop;
  cmd_t               fifo_head;
  logic               init_busy;

  // Configuration registers; writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cov_q <= MAX_RESET;
      limit_q   <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MAX_COVERAGE: max_cov_q <= COUNT_W'(cfg_data_i);
        REG_POSITIONS:    limit_q   <= LIMIT_W'(cfg_data_i);
        default: begin
          max_cov_q <= max_cov_q;
        end
      endcase
    end
  end

  sct_front u_front (
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_req_i           (in_req_i),
    .positions_in_use_i (limit_q),
    .fifo_full_i        (fifo_full),
    .init_busy_i        (init_busy),
    .push_o             (push),
    .push_cmd_o         (push_cmd)
  );

  sct_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (fifo_full),
    .pop_i      (fifo_pop),
    .empty_o    (fifo_empty),
    .head_o     (fifo_head)
  );

  sct_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_cmd_i   (fifo_head),
    .fifo_pop_o   (fifo_pop),
    .max_cov_i    (max_cov_q),
    .init_busy_o  (init_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule

`default_nettype wire
